// ===== hdl/cfb_pkg.sv =====
package cfb_pkg;

    // frame layout
    localparam int unsigned HDR_LEN   = 4;
    localparam int unsigned PAY_BYTES = 4;
    localparam int unsigned FRM_BYTES = HDR_LEN + PAY_BYTES;

    // largest payload a frame may carry
    localparam logic [3:0] MAX_PAYLOAD = 4'd4;

    // fixed header byte and frame sizes per command class
    localparam logic [7:0] HDR_MARK     = 8'd4;
    localparam logic [3:0] SIZE_SHORT   = 4'd4;
    localparam logic [3:0] SIZE_MEDIUM  = 4'd6;
    localparam logic [3:0] SIZE_LONG    = 4'd8;

    // crc-16/xmodem
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // configuration register indexes
    localparam logic [2:0] REG_DEV_ADDR     = 3'd0;
    localparam logic [2:0] REG_CODE_SCANNER = 3'd1;
    localparam logic [2:0] REG_CODE_DATE    = 3'd2;
    localparam logic [2:0] REG_CODE_COMMON  = 3'd3;
    localparam logic [2:0] REG_CODE_WOOD    = 3'd4;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CMD   = 2'd1,
        ST_BAD_COUNT = 2'd2
    } t_status;

    // one frame as it moves down the pipeline
    typedef struct packed {
        t_status                      status;
        logic [3:0]                   size;
        logic [FRM_BYTES-1:0][7:0]    bytes;
        logic [15:0]                  crc;
    } t_frame;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hdl/cfb_frame_ser.sv =====
module cfb_frame_ser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cfb_pkg::t_frame   i_frame,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_frame_byte,
    output logic              o_last_byte,
    output logic [1:0]        o_status
);

    logic            r_busy;
    cfb_pkg::t_frame r_frame;
    logic [3:0]      r_idx;
    logic            is_err;
    logic            is_last;
    logic            take;

    // end of frame: error results are a single transaction
    assign is_err  = (r_frame.status != cfb_pkg::ST_OK);
    assign is_last = is_err || (r_idx == r_frame.size + 4'd1);
    assign take    = r_busy && !i_stall;
    assign o_ready = !r_busy || (take && is_last);

    // frame holding register and byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
        end else if (o_ready) begin
            r_busy  <= i_valid;
            r_frame <= i_frame;
            r_idx   <= 4'd0;
        end else if (take) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    // byte select: header and payload, then crc high, then crc low; a zero byte for an error result
    always_comb begin
        if (is_err) begin
            o_frame_byte = 8'h00;
        end else if (r_idx < r_frame.size) begin
            o_frame_byte = r_frame.bytes[r_idx[2:0]];
        end else if (r_idx == r_frame.size) begin
            o_frame_byte = r_frame.crc[15:8];
        end else begin
            o_frame_byte = r_frame.crc[7:0];
        end
    end

    assign o_valid     = r_busy;
    assign o_last_byte = is_last;
    assign o_status    = r_frame.status;

endmodule

// ===== hdl/command_frame_builder_crc16.sv =====
// Command frame builder. Each request transaction (command, payload count, payload bytes)
// becomes one byte frame: address, size, command, 4, payload, then a crc-16/xmodem over
// all of that, high byte first; an unknown command or a wrong payload count gives a single
// error transaction instead. A request can enter every cycle while o_stall is low. The first
// byte reaches the output through the decode stage, which captures the request at the
// accepting edge, eight crc stages of one byte each, then the output register. The
// byte-wide output register sends a frame of size s as s + 2 bytes (6, 8 or 10), an error
// result as a single byte; meanwhile the empty pipeline stages keep taking requests.
// Configuration writes are meant for idle periods only.
module command_frame_builder_crc16 #(
    parameter logic [3:0] MAX_PAYLOAD = cfb_pkg::MAX_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // requests
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_command,
    input  logic [2:0]  i_payload_count,
    input  logic [31:0] i_payload_bytes,
    // frame bytes
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte,
    output logic [1:0]  o_status
);

    localparam int unsigned NSTG = cfb_pkg::FRM_BYTES + 1;

    logic [7:0] r_dev_addr;
    logic [7:0] r_code_scanner;
    logic [7:0] r_code_date;
    logic [7:0] r_code_common;
    logic [7:0] r_code_wood;

    logic [3:0]         dec_size;
    logic [3:0]         dec_npay;
    cfb_pkg::t_status   dec_status;
    cfb_pkg::t_frame    dec_frame;

    logic [NSTG-1:0]    r_vld;
    cfb_pkg::t_frame    r_stg [NSTG];
    cfb_pkg::t_frame    n_stg [NSTG];
    logic [NSTG:0]      stg_rdy;
    logic               ser_rdy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr     <= 8'd1;
            r_code_scanner <= 8'd110;
            r_code_date    <= 8'd100;
            r_code_common  <= 8'd101;
            r_code_wood    <= 8'd103;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cfb_pkg::REG_DEV_ADDR:     r_dev_addr     <= i_cfg_data;
                cfb_pkg::REG_CODE_SCANNER: r_code_scanner <= i_cfg_data;
                cfb_pkg::REG_CODE_DATE:    r_code_date    <= i_cfg_data;
                cfb_pkg::REG_CODE_COMMON:  r_code_common  <= i_cfg_data;
                cfb_pkg::REG_CODE_WOOD:    r_code_wood    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // command match in priority order, then payload count check
    always_comb begin
        dec_status = cfb_pkg::ST_OK;
        dec_size   = cfb_pkg::SIZE_SHORT;
        if (i_command == r_code_scanner) begin
            dec_size = cfb_pkg::SIZE_SHORT;
        end else if (i_command == r_code_date) begin
            dec_size = cfb_pkg::SIZE_LONG;
        end else if (i_command == r_code_common) begin
            dec_size = cfb_pkg::SIZE_SHORT;
        end else if (i_command == r_code_wood) begin
            dec_size = cfb_pkg::SIZE_MEDIUM;
        end else begin
            dec_status = cfb_pkg::ST_BAD_CMD;
        end
        dec_npay = dec_size - 4'(cfb_pkg::HDR_LEN);
        if (dec_status == cfb_pkg::ST_OK &&
            ({1'b0, i_payload_count} != dec_npay || dec_npay > MAX_PAYLOAD)) begin
            dec_status = cfb_pkg::ST_BAD_COUNT;
        end
    end

    // header and payload bytes of the frame
    always_comb begin
        dec_frame.status   = dec_status;
        dec_frame.size     = dec_size;
        dec_frame.crc      = cfb_pkg::CRC_INIT;
        dec_frame.bytes[0] = r_dev_addr;
        dec_frame.bytes[1] = {4'd0, dec_size};
        dec_frame.bytes[2] = i_command;
        dec_frame.bytes[3] = cfb_pkg::HDR_MARK;
        for (int k = 0; k < cfb_pkg::PAY_BYTES; k++) begin
            dec_frame.bytes[cfb_pkg::HDR_LEN + k] = i_payload_bytes[8*k +: 8];
        end
    end

    // per-stage advance: a stage moves when empty or when its successor moves
    assign stg_rdy[NSTG] = ser_rdy;
    generate
        for (genvar j = 0; j < NSTG; j++) begin : g_rdy
            assign stg_rdy[j] = !r_vld[j] || stg_rdy[j+1];
        end
    endgenerate
    assign o_stall = !stg_rdy[0];

    // decode stage
    assign n_stg[0] = dec_frame;

    // crc stages, one frame byte each
    generate
        for (genvar j = 1; j < NSTG; j++) begin : g_crc
            localparam logic [3:0] BYTE_IDX = 4'(j - 1);
            always_comb begin
                n_stg[j] = r_stg[j-1];
                if (BYTE_IDX < r_stg[j-1].size) begin
                    n_stg[j].crc = cfb_pkg::crc_byte(r_stg[j-1].crc,
                                                     r_stg[j-1].bytes[BYTE_IDX[2:0]]);
                end
            end
        end
    endgenerate

    // pipeline registers
    generate
        for (genvar j = 0; j < NSTG; j++) begin : g_stg
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else if (stg_rdy[j]) begin
                    r_vld[j] <= (j == 0) ? i_valid : r_vld[(j == 0) ? 0 : j-1];
                    r_stg[j] <= n_stg[j];
                end
            end
        end
    endgenerate

    // byte serializer and output register
    cfb_frame_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_vld[NSTG-1]),
        .o_ready      (ser_rdy),
        .i_frame      (r_stg[NSTG-1]),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte),
        .o_status     (o_status)
    );

    // an accepted request lands in the decode stage
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted request not captured");

    // input is only held off when the decode stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_vld[0])
        else $error("stall with empty decode stage");

    // error results are a single zero byte
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != cfb_pkg::ST_OK) |-> (o_last_byte && o_frame_byte == 8'h00))
        else $error("error result not a single zero byte");

    // a frame byte that ends a frame frees the output register for the last crc stage
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_byte) |-> ser_rdy)
        else $error("serializer did not free after last byte");

endmodule
